FILE: rtl/number_token_length_scanner_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the number token length scanner
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef NUMBER_TOKEN_LENGTH_SCANNER_ASSERT_SVH
`define NUMBER_TOKEN_LENGTH_SCANNER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NTLS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NTLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ntls_pkg.sv
// ----------------------------------------------------------------------------
// ntls_pkg
// Types and helper functions shared by the number token length scanner.
// ----------------------------------------------------------------------------
package ntls_pkg;

  // Character classes produced by the front end.
  typedef enum logic [4:0] {
    CL_OTHER,
    CL_DIGIT,
    CL_SIGN,
    CL_DOT,
    CL_EXP,
    CL_I,
    CL_N,
    CL_F,
    CL_T,
    CL_Y,
    CL_A,
    CL_SLASH,
    CL_INFSIGN,
    CL_GLYPH,
    CL_SUP,
    CL_FSLASH,
    CL_SUB
  } cls_e;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SIGN,
    PH_INT,
    PH_FRAC,
    PH_EXP,
    PH_EXPSIGN,
    PH_EXPDIG,
    PH_TSTART,
    PH_SPEC_INF,
    PH_SPEC_NAN,
    PH_GLYPH,
    PH_SUP,
    PH_SLASH,
    PH_SUB
  } phase_e;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_DECIMAL,
    KIND_RATIONAL,
    KIND_SPECIAL,
    KIND_FRACTION
  } kind_e;

  // One classified character as held in the queue.
  typedef struct packed {
    cls_e       cls;
    logic [2:0] bytes;
    logic       start;
  } entry_t;

  // One result item.
  typedef struct packed {
    logic [7:0] len;
    kind_e      kind;
    logic       imag;
    logic       too_long;
  } res_t;

  typedef struct packed {
    logic       over;
    logic [7:0] len;
  } sum_t;

  // Saturating length add.
  function automatic sum_t sat_add(logic [7:0] a, logic [2:0] b, logic [7:0] cap);
    logic [8:0] s;
    sum_t       r;
    s = {1'b0, a} + {6'b0, b};
    if (s > {1'b0, cap}) begin
      r.over = 1'b1;
      r.len  = cap;
    end else begin
      r.over = 1'b0;
      r.len  = s[7:0];
    end
    return r;
  endfunction

  // Expected letter at position pos of the word "infinity".
  function automatic logic inf_letter(logic [2:0] pos, cls_e c);
    logic ok;
    case (pos)
      3'd0, 3'd3, 3'd5: ok = (c == CL_I);
      3'd1, 3'd4:       ok = (c == CL_N);
      3'd2:             ok = (c == CL_F);
      3'd6:             ok = (c == CL_T);
      default:          ok = (c == CL_Y);
    endcase
    return ok;
  endfunction

  // Expected letter at position pos of the word "nan".
  function automatic logic nan_letter(logic [1:0] pos, cls_e c);
    logic ok;
    case (pos)
      2'd1:    ok = (c == CL_A);
      default: ok = (c == CL_N);
    endcase
    return ok;
  endfunction

endpackage

FILE: rtl/ntls_front.sv
// ----------------------------------------------------------------------------
// ntls_front
// Accepts characters and reduces each code point to a character class.
// ----------------------------------------------------------------------------
module ntls_front (
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  input  logic [20:0]           code_point_i,
  input  logic [2:0]            char_bytes_i,
  input  logic                  starts_scan_i,
  input  logic                  text_end_i,
  input  logic                  q_ready_i,
  output logic                  q_push_o,
  output ntls_pkg::entry_t      q_entry_o
);

  localparam logic [20:0] CpInfSign  = 21'h0221E;
  localparam logic [20:0] CpFracSl   = 21'h02044;
  localparam logic [20:0] CpSup2     = 21'h000B2;
  localparam logic [20:0] CpSup3     = 21'h000B3;
  localparam logic [20:0] CpSup1     = 21'h000B9;
  localparam logic [20:0] CpSup0     = 21'h02070;
  localparam logic [20:0] CpSup4     = 21'h02074;
  localparam logic [20:0] CpSup9     = 21'h02079;
  localparam logic [20:0] CpGlyphLo  = 21'h000BC;
  localparam logic [20:0] CpGlyphHi  = 21'h000BE;
  localparam logic [20:0] CpVulgLo   = 21'h02150;
  localparam logic [20:0] CpVulgHi   = 21'h0215E;
  localparam logic [20:0] CpSub0     = 21'h02080;
  localparam logic [20:0] CpSub9     = 21'h02089;

  function automatic ntls_pkg::cls_e classify(logic [20:0] c);
    ntls_pkg::cls_e k;
    if (c >= 21'h30 && c <= 21'h39)                   k = ntls_pkg::CL_DIGIT;
    else if (c == 21'h2B || c == 21'h2D)              k = ntls_pkg::CL_SIGN;
    else if (c == 21'h2E)                             k = ntls_pkg::CL_DOT;
    else if (c == 21'h65 || c == 21'h45)              k = ntls_pkg::CL_EXP;
    else if (c == 21'h69 || c == 21'h49)              k = ntls_pkg::CL_I;
    else if (c == 21'h6E || c == 21'h4E)              k = ntls_pkg::CL_N;
    else if (c == 21'h66 || c == 21'h46)              k = ntls_pkg::CL_F;
    else if (c == 21'h74 || c == 21'h54)              k = ntls_pkg::CL_T;
    else if (c == 21'h79 || c == 21'h59)              k = ntls_pkg::CL_Y;
    else if (c == 21'h61 || c == 21'h41)              k = ntls_pkg::CL_A;
    else if (c == 21'h2F)                             k = ntls_pkg::CL_SLASH;
    else if (c == CpInfSign)                          k = ntls_pkg::CL_INFSIGN;
    else if ((c >= CpGlyphLo && c <= CpGlyphHi) ||
             (c >= CpVulgLo && c <= CpVulgHi))        k = ntls_pkg::CL_GLYPH;
    else if (c == CpSup2 || c == CpSup3 || c == CpSup1 || c == CpSup0 ||
             (c >= CpSup4 && c <= CpSup9))            k = ntls_pkg::CL_SUP;
    else if (c == CpFracSl)                           k = ntls_pkg::CL_FSLASH;
    else if (c >= CpSub0 && c <= CpSub9)              k = ntls_pkg::CL_SUB;
    else                                              k = ntls_pkg::CL_OTHER;
    return k;
  endfunction

  assign s_ready_o = q_ready_i;
  assign q_push_o  = s_valid_i & q_ready_i;

  // The end of text is a character of no class and no width.
  always_comb begin
    q_entry_o.cls   = text_end_i ? ntls_pkg::CL_OTHER : classify(code_point_i);
    q_entry_o.bytes = text_end_i ? 3'd0 : char_bytes_i;
    q_entry_o.start = starts_scan_i;
  end

endmodule

FILE: rtl/ntls_fifo.sv
// ----------------------------------------------------------------------------
// ntls_fifo
// Two-entry queue between the classifying front end and the recogniser.
// ----------------------------------------------------------------------------
`include "number_token_length_scanner_assert.svh"

module ntls_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ntls_pkg::entry_t  push_entry_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              pop_i,
  output ntls_pkg::entry_t  pop_entry_o
);

  ntls_pkg::entry_t mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;

  assign ready_o     = (cnt_q != 2'd2);
  assign valid_o     = (cnt_q != 2'd0);
  assign pop_entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  `NTLS_ASSERT_IMPL(a_no_pop_empty, pop_i, cnt_q != 2'd0, "queue popped while empty")
  `NTLS_ASSERT_IMPL(a_no_push_full, push_i, cnt_q != 2'd2, "queue pushed while full")
  `NTLS_ASSERT_NEXT(a_cnt_grows, push_i && !pop_i, cnt_q == 2'($past(cnt_q) + 2'd1), "queue count did not grow")

endmodule

FILE: rtl/ntls_back.sv
// ----------------------------------------------------------------------------
// ntls_back
// Recogniser state machine with saturating lengths and the result register.
// ----------------------------------------------------------------------------
`include "number_token_length_scanner_assert.svh"

module ntls_back #(
  parameter int MAX_TOKEN_BYTES = 255
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              allow_i,
  input  logic              q_valid_i,
  input  ntls_pkg::entry_t  q_entry_i,
  output logic              q_pop_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output ntls_pkg::res_t    m_res_o
);

  localparam int         CapInt = (MAX_TOKEN_BYTES < 255) ? MAX_TOKEN_BYTES : 255;
  localparam logic [7:0] LenCap = 8'(CapInt);

  ntls_pkg::phase_e ph_q, ph_d;
  logic [7:0]       comm_q, comm_d;
  logic [7:0]       tent_q, tent_d;
  logic [3:0]       pos_q, pos_d;
  logic             tail_q, tail_d;
  logic             over_q, over_d;

  logic             out_valid_q, out_valid_d;
  ntls_pkg::res_t   out_res_q;

  ntls_pkg::sum_t   tadd, cadd;
  ntls_pkg::cls_e   cls;
  logic [7:0]       b8;
  logic             do_take, do_commit, dec_done;
  logic             emit;
  logic [7:0]       e_len;
  ntls_pkg::kind_e  e_kind, kind_dec;
  logic             e_imag;
  ntls_pkg::res_t   res;

  assign cls      = q_entry_i.cls;
  assign b8       = {5'b0, q_entry_i.bytes};
  assign tadd     = ntls_pkg::sat_add(tent_q, q_entry_i.bytes, LenCap);
  assign cadd     = ntls_pkg::sat_add(comm_q, q_entry_i.bytes, LenCap);
  assign kind_dec = tail_q ? ntls_pkg::KIND_RATIONAL : ntls_pkg::KIND_DECIMAL;

  // A new character is taken whenever the result register is free or drains.
  assign q_pop_o   = q_valid_i & (~out_valid_q | m_ready_i);
  assign m_valid_o = out_valid_q;
  assign m_res_o   = out_res_q;

  always_comb begin
    ph_d      = ph_q;
    comm_d    = comm_q;
    tent_d    = tent_q;
    pos_d     = pos_q;
    tail_d    = tail_q;
    over_d    = over_q;
    do_take   = 1'b0;
    do_commit = 1'b0;
    dec_done  = 1'b0;
    emit      = 1'b0;
    e_len     = 8'd0;
    e_kind    = ntls_pkg::KIND_NONE;
    e_imag    = 1'b0;

    if (q_entry_i.start) begin
      // Fresh scan: a single character never reaches the cap.
      comm_d = 8'd0;
      tent_d = 8'd0;
      pos_d  = 4'd0;
      tail_d = 1'b0;
      over_d = 1'b0;
      if (cls == ntls_pkg::CL_SIGN) begin
        tent_d = b8;
        ph_d   = ntls_pkg::PH_SIGN;
      end else if (cls == ntls_pkg::CL_DIGIT) begin
        tent_d = b8;
        comm_d = b8;
        ph_d   = ntls_pkg::PH_INT;
      end else if (cls == ntls_pkg::CL_DOT) begin
        tent_d = b8;
        comm_d = b8;
        ph_d   = ntls_pkg::PH_FRAC;
      end else if (allow_i && cls == ntls_pkg::CL_INFSIGN) begin
        emit   = 1'b1;
        e_len  = b8;
        e_kind = ntls_pkg::KIND_SPECIAL;
      end else if (allow_i && cls == ntls_pkg::CL_I) begin
        tent_d = b8;
        pos_d  = 4'd1;
        ph_d   = ntls_pkg::PH_SPEC_INF;
      end else if (allow_i && cls == ntls_pkg::CL_N) begin
        tent_d = b8;
        pos_d  = 4'd1;
        ph_d   = ntls_pkg::PH_SPEC_NAN;
      end else if (cls == ntls_pkg::CL_GLYPH) begin
        tent_d = b8;
        comm_d = b8;
        ph_d   = ntls_pkg::PH_GLYPH;
      end else if (cls == ntls_pkg::CL_SUP) begin
        tent_d = b8;
        ph_d   = ntls_pkg::PH_SUP;
      end else begin
        emit = 1'b1;
      end
    end else begin
      unique case (ph_q)
        ntls_pkg::PH_IDLE: begin
        end
        ntls_pkg::PH_TSTART, ntls_pkg::PH_SIGN: begin
          if (ph_q == ntls_pkg::PH_TSTART && cls == ntls_pkg::CL_SIGN) begin
            do_take = 1'b1;
            ph_d    = ntls_pkg::PH_SIGN;
          end else if (cls == ntls_pkg::CL_DIGIT) begin
            do_take   = 1'b1;
            do_commit = 1'b1;
            ph_d      = ntls_pkg::PH_INT;
          end else if (cls == ntls_pkg::CL_DOT) begin
            do_take   = 1'b1;
            do_commit = 1'b1;
            ph_d      = ntls_pkg::PH_FRAC;
          end else begin
            // Reported as a plain decimal even inside a rational tail.
            emit   = 1'b1;
            e_len  = comm_q;
            e_kind = ntls_pkg::KIND_DECIMAL;
          end
        end
        ntls_pkg::PH_INT: begin
          if (cls == ntls_pkg::CL_DIGIT) begin
            do_take   = 1'b1;
            do_commit = 1'b1;
          end else if (cls == ntls_pkg::CL_DOT) begin
            do_take   = 1'b1;
            do_commit = 1'b1;
            ph_d      = ntls_pkg::PH_FRAC;
          end else if (cls == ntls_pkg::CL_EXP) begin
            do_take = 1'b1;
            ph_d    = ntls_pkg::PH_EXP;
          end else begin
            dec_done = 1'b1;
          end
        end
        ntls_pkg::PH_FRAC: begin
          if (cls == ntls_pkg::CL_DIGIT) begin
            do_take   = 1'b1;
            do_commit = 1'b1;
          end else if (cls == ntls_pkg::CL_EXP) begin
            do_take = 1'b1;
            ph_d    = ntls_pkg::PH_EXP;
          end else begin
            dec_done = 1'b1;
          end
        end
        ntls_pkg::PH_EXP, ntls_pkg::PH_EXPSIGN: begin
          if (ph_q == ntls_pkg::PH_EXP && cls == ntls_pkg::CL_SIGN) begin
            do_take = 1'b1;
            ph_d    = ntls_pkg::PH_EXPSIGN;
          end else if (cls == ntls_pkg::CL_DIGIT) begin
            do_take   = 1'b1;
            do_commit = 1'b1;
            ph_d      = ntls_pkg::PH_EXPDIG;
          end else begin
            // No digit after the exponent mark: the exponent is dropped.
            emit   = 1'b1;
            e_len  = comm_q;
            e_kind = kind_dec;
          end
        end
        ntls_pkg::PH_EXPDIG: begin
          if (cls == ntls_pkg::CL_DIGIT) begin
            do_take   = 1'b1;
            do_commit = 1'b1;
          end else begin
            dec_done = 1'b1;
          end
        end
        ntls_pkg::PH_SPEC_INF: begin
          if (!pos_q[3] && ntls_pkg::inf_letter(pos_q[2:0], cls)) begin
            do_take = 1'b1;
            pos_d   = pos_q + 4'd1;
            if (pos_q == 4'd2) begin
              do_commit = 1'b1;
            end
            if (pos_q == 4'd7) begin
              emit   = 1'b1;
              e_len  = tadd.len;
              e_kind = ntls_pkg::KIND_SPECIAL;
            end
          end else if (pos_q >= 4'd3) begin
            emit   = 1'b1;
            e_len  = comm_q;
            e_kind = ntls_pkg::KIND_SPECIAL;
          end else begin
            emit = 1'b1;
          end
        end
        ntls_pkg::PH_SPEC_NAN: begin
          if (pos_q < 4'd3 && ntls_pkg::nan_letter(pos_q[1:0], cls)) begin
            do_take = 1'b1;
            pos_d   = pos_q + 4'd1;
            if (pos_q == 4'd2) begin
              emit   = 1'b1;
              e_len  = tadd.len;
              e_kind = ntls_pkg::KIND_SPECIAL;
            end
          end else begin
            emit = 1'b1;
          end
        end
        ntls_pkg::PH_GLYPH: begin
          emit   = 1'b1;
          e_kind = ntls_pkg::KIND_FRACTION;
          if (cls == ntls_pkg::CL_I) begin
            e_len  = cadd.len;
            e_imag = 1'b1;
            over_d = over_q | cadd.over;
          end else begin
            e_len = comm_q;
          end
        end
        ntls_pkg::PH_SUP: begin
          if (cls == ntls_pkg::CL_SUP) begin
            do_take = 1'b1;
          end else if (cls == ntls_pkg::CL_FSLASH) begin
            do_take = 1'b1;
            ph_d    = ntls_pkg::PH_SLASH;
          end else begin
            emit = 1'b1;
          end
        end
        ntls_pkg::PH_SLASH: begin
          if (cls == ntls_pkg::CL_SUB) begin
            do_take   = 1'b1;
            do_commit = 1'b1;
            ph_d      = ntls_pkg::PH_SUB;
          end else begin
            emit = 1'b1;
          end
        end
        ntls_pkg::PH_SUB: begin
          if (cls == ntls_pkg::CL_SUB) begin
            do_take   = 1'b1;
            do_commit = 1'b1;
          end else begin
            emit   = 1'b1;
            e_kind = ntls_pkg::KIND_FRACTION;
            if (cls == ntls_pkg::CL_I) begin
              e_len  = cadd.len;
              e_imag = 1'b1;
              over_d = over_q | cadd.over;
            end else begin
              e_len = comm_q;
            end
          end
        end
        default: begin
          ph_d = ntls_pkg::PH_IDLE;
        end
      endcase

      if (do_take) begin
        tent_d = tadd.len;
        over_d = over_q | tadd.over;
        if (do_commit) begin
          comm_d = tadd.len;
        end
      end

      // End of a decimal part: rational slash, imaginary suffix or stop.
      if (dec_done) begin
        if (!tail_q && cls == ntls_pkg::CL_SLASH) begin
          tent_d = cadd.len;
          over_d = over_q | cadd.over;
          tail_d = 1'b1;
          ph_d   = ntls_pkg::PH_TSTART;
        end else if (cls == ntls_pkg::CL_I) begin
          emit   = 1'b1;
          e_len  = cadd.len;
          e_kind = kind_dec;
          e_imag = 1'b1;
          over_d = over_q | cadd.over;
        end else begin
          emit   = 1'b1;
          e_len  = comm_q;
          e_kind = kind_dec;
        end
      end
    end

    if (emit) begin
      ph_d = ntls_pkg::PH_IDLE;
    end

    res.len      = e_len;
    res.kind     = (e_len == 8'd0) ? ntls_pkg::KIND_NONE : e_kind;
    res.imag     = (e_len == 8'd0) ? 1'b0 : e_imag;
    res.too_long = over_d & (e_len == LenCap);

    out_valid_d = out_valid_q;
    if (q_pop_o && emit) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= ntls_pkg::PH_IDLE;
      comm_q      <= 8'd0;
      tent_q      <= 8'd0;
      pos_q       <= 4'd0;
      tail_q      <= 1'b0;
      over_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (q_pop_o) begin
        ph_q   <= ph_d;
        comm_q <= comm_d;
        tent_q <= tent_d;
        pos_q  <= pos_d;
        tail_q <= tail_d;
        over_q <= over_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && emit) begin
      out_res_q <= res;
    end
  end

  `NTLS_ASSERT_IMPL(a_comm_le_tent, 1'b1, comm_q <= tent_q, "committed length above tentative")
  `NTLS_ASSERT_IMPL(a_zero_is_none, out_valid_q && out_res_q.len == 8'd0, out_res_q.kind == ntls_pkg::KIND_NONE && !out_res_q.imag, "empty token with a kind")
  `NTLS_ASSERT_IMPL(a_long_at_cap, out_valid_q && out_res_q.too_long, out_res_q.len == LenCap, "overflow flag below the cap")

endmodule

FILE: rtl/number_token_length_scanner.sv
// ----------------------------------------------------------------------------
// number_token_length_scanner
// The character that settles a result passes through the queue, and the result
// is then held in the recogniser's result register.
// Throughput: one character per cycle while each result is taken as it is issued.
// Reset (rst_ni low, asynchronous): recogniser idle, queue empty, no result
// pending, allow_special_values set to 1.
// ----------------------------------------------------------------------------
//
// The block reports the byte length of the longest number token starting at a
// scan position. Characters arrive on the slave stream with their encoded
// byte widths; a character flagged as a scan start opens a new scan and drops
// any unfinished one.
//
// The front end classifies every accepted code point into a small class code
// (digit, sign, dot, exponent mark, the letters of the special names, slash,
// fraction glyphs, superscript and subscript digits and so on). The classes
// travel through a two-entry queue to the recogniser, which holds the scan
// phase, the committed and tentative lengths, the position inside a special
// name, and the rational tail and overflow flags. Each transaction that
// settles a token loads the result register. While that result waits without
// being taken, the recogniser takes no further character from the queue; it
// carries on in the cycle in which the result is accepted, so a result that
// is taken at once holds up nothing, and a stalled result stream holds up the
// character stream once the two queue entries have filled.
//
// Lengths saturate at MAX_TOKEN_BYTES or 255, whichever is smaller.
//
// The single configuration register, allow_special_values, sits at byte
// address 0 of the APB-style port; writes complete in the access phase.

module number_token_length_scanner #(
  parameter int MAX_TOKEN_BYTES = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Character stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [20:0] code_point, [23:21] char_bytes
  input  logic [1:0]  s_axis_tuser,   // [0] starts_scan, [1] text_end

  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] match_bytes, [10:8] token_kind, rest 0
  output logic [1:0]  m_axis_tuser,   // [0] imaginary, [1] too_long

  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic             allow_q, allow_d;
  logic             cfg_wr;

  logic             q_push, q_ready, q_valid, q_pop;
  ntls_pkg::entry_t push_entry, pop_entry;
  ntls_pkg::res_t   res;

  // Register 0 is the only one; bit 2 of the address selects beyond it.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & ~paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {31'd0, allow_q};

  always_comb begin
    allow_d = allow_q;
    if (cfg_wr) begin
      allow_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_q <= 1'b1;
    end else begin
      allow_q <= allow_d;
    end
  end

  // Classifying front end.
  ntls_front u_front (
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .code_point_i  (s_axis_tdata[20:0]),
    .char_bytes_i  (s_axis_tdata[23:21]),
    .starts_scan_i (s_axis_tuser[0]),
    .text_end_i    (s_axis_tuser[1]),
    .q_ready_i     (q_ready),
    .q_push_o      (q_push),
    .q_entry_o     (push_entry)
  );

  // Decoupling queue.
  ntls_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (push_entry),
    .ready_o      (q_ready),
    .valid_o      (q_valid),
    .pop_i        (q_pop),
    .pop_entry_o  (pop_entry)
  );

  // Recogniser and result register.
  ntls_back #(
    .MAX_TOKEN_BYTES (MAX_TOKEN_BYTES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .allow_i   (allow_q),
    .q_valid_i (q_valid),
    .q_entry_i (pop_entry),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_res_o   (res)
  );

  assign m_axis_tdata = {5'd0, res.kind, res.len};
  assign m_axis_tuser = {res.too_long, res.imag};

endmodule

FILE: sim/number_token_length_scanner_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Number token length scanner testbench
// A queue-fed driver streams characters with random gaps, and a clocked
// monitor predicts each token length from its own recogniser and compares
// every result field. allow_special_values is switched between phases.
// ----------------------------------------------------------------------------
module number_token_length_scanner_test;

  localparam int          MAX_TOKEN         = 255;
  localparam int          LEN_CAP           = (MAX_TOKEN < 255) ? MAX_TOKEN : 255;
  localparam logic [2:0]  REG_ALLOW_SPECIAL = 3'd0;
  localparam int          SETTLE_CYCLES     = 8;
  localparam int          PHASE_CHARS       = 220;

  localparam int unsigned NO_CHAR           = 32'hFFFF_FFFF;
  localparam int unsigned CH_PLUS           = 8'h2B;
  localparam int unsigned CH_MINUS          = 8'h2D;
  localparam int unsigned CH_DOT            = 8'h2E;
  localparam int unsigned CH_SLASH          = 8'h2F;
  localparam int unsigned CH_0              = 8'h30;
  localparam int unsigned CH_9              = 8'h39;
  localparam int unsigned CH_UE             = 8'h45;
  localparam int unsigned CH_LE             = 8'h65;
  localparam int unsigned CH_UI             = 8'h49;
  localparam int unsigned CH_LI             = 8'h69;
  localparam int unsigned CP_INFINITY       = 'h221E;
  localparam int unsigned CP_FRACTION_SLASH = 'h2044;
  localparam int unsigned CP_SUB_ZERO       = 'h2080;
  localparam int unsigned CP_SUB_NINE       = 'h2089;

  typedef struct packed {
    logic [20:0] cp;
    logic [2:0]  nbytes;
    logic        start;
    logic        tend;
  } char_t;

  typedef struct packed {
    logic [7:0]      nbytes;
    ntls_pkg::kind_e kind;
    logic            imag;
    logic            sat;
  } token_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [20:0] code_point, [23:21] char_bytes
  logic [1:0]  s_axis_tuser = '0;   // [0] starts_scan, [1] text_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [7:0] match_bytes, [10:8] token_kind
  logic [1:0]  m_axis_tuser;        // [0] imaginary, [1] too_long
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  char_t       pending_chars[$];
  token_t      expected_tokens[$];
  char_t       outgoing;
  token_t      want;
  logic        s_fire = 1'b0;
  int          cycle_no = 0;
  int          fault_count = 0;
  int          chars_queued = 0;
  logic        open_pending = 1'b0;
  logic        calm;

  // Recogniser copy kept by the testbench.
  logic             allow_special = 1'b1;
  ntls_pkg::phase_e scan_ph = ntls_pkg::PH_IDLE;
  logic [7:0]       commit_len = '0;
  logic [7:0]       trial_len = '0;
  int               name_pos = 0;
  logic             tail_seen = 1'b0;
  logic             len_overflow = 1'b0;
  string            word_inf = "infinity";
  string            word_nan = "nan";
  int unsigned near_misses[13] = '{'hBB, 'hBF, 'h214F, 'h215F, 'h2071, 'h2073, 'h207A,
                                   'h207F, 'h208A, 'h221D, 'h221F, 'h2043, 'h2045};

  number_token_length_scanner #(
    .MAX_TOKEN_BYTES(MAX_TOKEN)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk_i = ~clk_i;

  // Toward the end of each period of the cycle counter, both sides run without gaps.
  assign calm = (cycle_no % 1000) >= 700;

  // ---------------------------------------------------------------- predictor
  function automatic logic is_digit(input int unsigned c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic logic is_sign(input int unsigned c);
    return c == CH_PLUS || c == CH_MINUS;
  endfunction

  function automatic logic is_exp_mark(input int unsigned c);
    return c == CH_LE || c == CH_UE;
  endfunction

  function automatic logic is_imag_mark(input int unsigned c);
    return c == CH_LI || c == CH_UI;
  endfunction

  function automatic logic is_super(input int unsigned c);
    return c == 'hB2 || c == 'hB3 || c == 'hB9 || c == 'h2070 || (c >= 'h2074 && c <= 'h2079);
  endfunction

  function automatic logic is_sub(input int unsigned c);
    return c >= CP_SUB_ZERO && c <= CP_SUB_NINE;
  endfunction

  function automatic logic is_glyph(input int unsigned c);
    return (c >= 'hBC && c <= 'hBE) || (c >= 'h2150 && c <= 'h215E);
  endfunction

  function automatic int unsigned lower_ascii(input int unsigned c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 32 : c;
  endfunction

  // Saturating length sum; a clipped sum marks the scan as overflowed.
  function automatic logic [7:0] grow(input logic [7:0] base, input logic [2:0] add);
    int unsigned total;
    total = base + add;
    if (total > LEN_CAP) begin
      len_overflow = 1'b1;
      return 8'(LEN_CAP);
    end
    return 8'(total);
  endfunction

  task automatic take_char(input logic [2:0] b);
    trial_len = grow(trial_len, b);
  endtask

  task automatic take_and_commit(input logic [2:0] b);
    trial_len  = grow(trial_len, b);
    commit_len = trial_len;
  endtask

  task automatic close_token(input logic [7:0] n, input ntls_pkg::kind_e k, input logic im);
    token_t t;
    t.nbytes = n;
    t.kind   = (n == 0) ? ntls_pkg::KIND_NONE : k;
    t.imag   = (n == 0) ? 1'b0 : im;
    t.sat    = len_overflow && (n == 8'(LEN_CAP));
    expected_tokens.push_back(t);
    scan_ph = ntls_pkg::PH_IDLE;
  endtask

  // A decimal part has ended: a first slash opens a rational tail.
  task automatic decimal_end(input int unsigned c, input logic [2:0] b);
    ntls_pkg::kind_e dk;
    dk = tail_seen ? ntls_pkg::KIND_RATIONAL : ntls_pkg::KIND_DECIMAL;
    if (!tail_seen && c == CH_SLASH) begin
      trial_len = grow(commit_len, b);
      tail_seen = 1'b1;
      scan_ph   = ntls_pkg::PH_TSTART;
    end else if (is_imag_mark(c)) begin
      close_token(grow(commit_len, b), dk, 1'b1);
    end else begin
      close_token(commit_len, dk, 1'b0);
    end
  endtask

  task automatic scan_char(input int unsigned cp_in, input logic [2:0] nb_in,
                           input logic start, input logic tend);
    int unsigned     c;
    logic [2:0]      b;
    ntls_pkg::kind_e dk;
    c  = tend ? NO_CHAR : cp_in;
    b  = tend ? 3'd0 : nb_in;
    dk = tail_seen ? ntls_pkg::KIND_RATIONAL : ntls_pkg::KIND_DECIMAL;
    if (start) begin
      commit_len   = '0;
      trial_len    = '0;
      name_pos     = 0;
      tail_seen    = 1'b0;
      len_overflow = 1'b0;
      if (is_sign(c)) begin
        take_char(b);
        scan_ph = ntls_pkg::PH_SIGN;
      end else if (is_digit(c)) begin
        take_and_commit(b);
        scan_ph = ntls_pkg::PH_INT;
      end else if (c == CH_DOT) begin
        take_and_commit(b);
        scan_ph = ntls_pkg::PH_FRAC;
      end else if (allow_special && c == CP_INFINITY) begin
        close_token(grow(8'd0, b), ntls_pkg::KIND_SPECIAL, 1'b0);
      end else if (allow_special && lower_ascii(c) == "i") begin
        take_char(b);
        name_pos = 1;
        scan_ph  = ntls_pkg::PH_SPEC_INF;
      end else if (allow_special && lower_ascii(c) == "n") begin
        take_char(b);
        name_pos = 1;
        scan_ph  = ntls_pkg::PH_SPEC_NAN;
      end else if (is_glyph(c)) begin
        take_and_commit(b);
        scan_ph = ntls_pkg::PH_GLYPH;
      end else if (is_super(c)) begin
        take_char(b);
        scan_ph = ntls_pkg::PH_SUP;
      end else begin
        close_token(8'd0, ntls_pkg::KIND_NONE, 1'b0);
      end
    end else if (scan_ph != ntls_pkg::PH_IDLE) begin
      case (scan_ph)
        ntls_pkg::PH_TSTART, ntls_pkg::PH_SIGN: begin
          // A tail may carry its own sign; a bare sign never completes.
          if (scan_ph == ntls_pkg::PH_TSTART && is_sign(c)) begin
            take_char(b);
            scan_ph = ntls_pkg::PH_SIGN;
          end else if (is_digit(c)) begin
            take_and_commit(b);
            scan_ph = ntls_pkg::PH_INT;
          end else if (c == CH_DOT) begin
            take_and_commit(b);
            scan_ph = ntls_pkg::PH_FRAC;
          end else begin
            close_token(commit_len, ntls_pkg::KIND_DECIMAL, 1'b0);
          end
        end
        ntls_pkg::PH_INT: begin
          if (is_digit(c)) begin
            take_and_commit(b);
          end else if (c == CH_DOT) begin
            take_and_commit(b);
            scan_ph = ntls_pkg::PH_FRAC;
          end else if (is_exp_mark(c)) begin
            take_char(b);
            scan_ph = ntls_pkg::PH_EXP;
          end else begin
            decimal_end(c, b);
          end
        end
        ntls_pkg::PH_FRAC: begin
          if (is_digit(c)) begin
            take_and_commit(b);
          end else if (is_exp_mark(c)) begin
            take_char(b);
            scan_ph = ntls_pkg::PH_EXP;
          end else begin
            decimal_end(c, b);
          end
        end
        ntls_pkg::PH_EXP, ntls_pkg::PH_EXPSIGN: begin
          // An exponent without digits is dropped from the token.
          if (scan_ph == ntls_pkg::PH_EXP && is_sign(c)) begin
            take_char(b);
            scan_ph = ntls_pkg::PH_EXPSIGN;
          end else if (is_digit(c)) begin
            take_and_commit(b);
            scan_ph = ntls_pkg::PH_EXPDIG;
          end else begin
            close_token(commit_len, dk, 1'b0);
          end
        end
        ntls_pkg::PH_EXPDIG: begin
          if (is_digit(c)) take_and_commit(b);
          else decimal_end(c, b);
        end
        ntls_pkg::PH_SPEC_INF: begin
          // "inf" is committed on its own; the full word closes the token.
          if (name_pos < 8 && lower_ascii(c) == word_inf[name_pos]) begin
            take_char(b);
            name_pos++;
            if (name_pos == 3) commit_len = trial_len;
            if (name_pos >= 8) close_token(trial_len, ntls_pkg::KIND_SPECIAL, 1'b0);
          end else if (name_pos >= 3) begin
            close_token(commit_len, ntls_pkg::KIND_SPECIAL, 1'b0);
          end else begin
            close_token(8'd0, ntls_pkg::KIND_NONE, 1'b0);
          end
        end
        ntls_pkg::PH_SPEC_NAN: begin
          if (name_pos < 3 && lower_ascii(c) == word_nan[name_pos]) begin
            take_char(b);
            name_pos++;
            if (name_pos >= 3) close_token(trial_len, ntls_pkg::KIND_SPECIAL, 1'b0);
          end else begin
            close_token(8'd0, ntls_pkg::KIND_NONE, 1'b0);
          end
        end
        ntls_pkg::PH_GLYPH: begin
          if (is_imag_mark(c)) begin
            close_token(grow(commit_len, b), ntls_pkg::KIND_FRACTION, 1'b1);
          end else begin
            close_token(commit_len, ntls_pkg::KIND_FRACTION, 1'b0);
          end
        end
        ntls_pkg::PH_SUP: begin
          if (is_super(c)) begin
            take_char(b);
          end else if (c == CP_FRACTION_SLASH) begin
            take_char(b);
            scan_ph = ntls_pkg::PH_SLASH;
          end else begin
            close_token(8'd0, ntls_pkg::KIND_NONE, 1'b0);
          end
        end
        ntls_pkg::PH_SLASH: begin
          if (is_sub(c)) begin
            take_and_commit(b);
            scan_ph = ntls_pkg::PH_SUB;
          end else begin
            close_token(8'd0, ntls_pkg::KIND_NONE, 1'b0);
          end
        end
        ntls_pkg::PH_SUB: begin
          if (is_sub(c)) begin
            take_and_commit(b);
          end else if (is_imag_mark(c)) begin
            close_token(grow(commit_len, b), ntls_pkg::KIND_FRACTION, 1'b1);
          end else begin
            close_token(commit_len, ntls_pkg::KIND_FRACTION, 1'b0);
          end
        end
        default: scan_ph = ntls_pkg::PH_IDLE;
      endcase
    end
  endtask

  // -------------------------------------------------------- driver and monitor
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_fire) begin
      if (pending_chars.size() != 0 && (calm || $urandom_range(0, 99) >= 17)) begin
        outgoing = pending_chars.pop_front();
        s_axis_tdata  <= {outgoing.nbytes, outgoing.cp};
        s_axis_tuser  <= {outgoing.tend, outgoing.start};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= calm || $urandom_range(0, 99) >= 17;
  end

  always @(posedge clk_i) begin
    cycle_no <= cycle_no + 1;
    if (!rst_ni) begin
      s_fire <= 1'b0;
    end else begin
      s_fire <= s_axis_tvalid && s_axis_tready;
      // Results are checked before this edge's character is predicted, since
      // a result always belongs to an earlier transaction.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_tokens.size() == 0) begin
          $error("result with nothing expected: match_bytes %0d", m_axis_tdata[7:0]);
          fault_count++;
        end else begin
          want = expected_tokens.pop_front();
          if (m_axis_tdata[7:0] !== want.nbytes) begin
            $error("match_bytes: expected %0d, got %0d", want.nbytes, m_axis_tdata[7:0]);
            fault_count++;
          end
          if (m_axis_tdata[10:8] !== want.kind) begin
            $error("token_kind: expected %0d, got %0d", want.kind, m_axis_tdata[10:8]);
            fault_count++;
          end
          if (m_axis_tuser[0] !== want.imag) begin
            $error("imaginary: expected %0d, got %0d", want.imag, m_axis_tuser[0]);
            fault_count++;
          end
          if (m_axis_tuser[1] !== want.sat) begin
            $error("too_long: expected %0d, got %0d", want.sat, m_axis_tuser[1]);
            fault_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        scan_char(s_axis_tdata[20:0], s_axis_tdata[23:21], s_axis_tuser[0], s_axis_tuser[1]);
      if (psel && penable && pwrite && pready && paddr == REG_ALLOW_SPECIAL)
        allow_special = pwdata[0];
    end
  end

  // ------------------------------------------------------------------ stimulus
  function automatic logic coin(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic [2:0] utf8_width(input int unsigned cp);
    if (cp < 'h80) return 3'd1;
    if (cp < 'h800) return 3'd2;
    if (cp < 'h10000) return 3'd3;
    return 3'd4;
  endfunction

  function automatic int unsigned rand_super();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return 'hB2;
      1:       return 'hB3;
      2:       return 'hB9;
      3:       return 'h2070;
      default: return 'h2074 + (r - 4);
    endcase
  endfunction

  function automatic int unsigned rand_char();
    string letters;
    letters = "iInNaAfFtTyY";
    case ($urandom_range(0, 11))
      0:       return CH_0 + $urandom_range(0, 9);
      1:       return coin(50) ? CH_PLUS : CH_MINUS;
      2:       return CH_DOT;
      3:       return coin(50) ? CH_LE : CH_UE;
      4:       return coin(50) ? CH_SLASH : CP_FRACTION_SLASH;
      5:       return letters[$urandom_range(0, 11)];
      6:       return $urandom_range(32, 126);
      7:       return near_misses[$urandom_range(0, 12)];
      8:       return CP_INFINITY;
      9:       return $urandom_range(0, 'h1FFFFF);
      10:      return $urandom_range('h100000, 'h1FFFFF);
      default: return $urandom_range(0, 'h7F);
    endcase
  endfunction

  // The first character after open_pending is raised carries the scan start.
  task automatic add_char(input int unsigned cp, input logic [2:0] nb, input logic tend);
    char_t ch;
    ch.cp        = cp[20:0];
    ch.nbytes    = nb;
    ch.start     = open_pending;
    ch.tend      = tend;
    open_pending = 1'b0;
    pending_chars.push_back(ch);
    chars_queued++;
  endtask

  // Natural encoded width, now and then an odd one.
  task automatic add_cp(input int unsigned cp);
    add_char(cp, coin(8) ? 3'($urandom_range(0, 7)) : utf8_width(cp), 1'b0);
  endtask

  task automatic add_text(input string s);
    for (int k = 0; k < s.len(); k++) add_char(s[k], 3'd1, 1'b0);
  endtask

  task automatic add_digit_run(input int n);
    repeat (n) add_cp(CH_0 + $urandom_range(0, 9));
  endtask

  task automatic add_decimal_body();
    int n;
    if (coin(30)) add_cp(coin(50) ? CH_PLUS : CH_MINUS);
    if (coin(3)) begin
      // Long run of wide digits to push the length into saturation.
      n = $urandom_range(40, 90);
      repeat (n) add_char(CH_0 + $urandom_range(0, 9), 3'($urandom_range(3, 7)), 1'b0);
    end else begin
      add_digit_run($urandom_range(0, 4));
    end
    if (coin(35)) begin
      add_cp(CH_DOT);
      add_digit_run($urandom_range(0, 3));
    end
    if (coin(35)) begin
      add_cp(coin(50) ? CH_LE : CH_UE);
      if (coin(40)) add_cp(coin(50) ? CH_PLUS : CH_MINUS);
      add_digit_run($urandom_range(0, 2));
    end
  endtask

  task automatic add_random_scan();
    int unsigned form;
    int          n;
    string       word;
    open_pending = 1'b1;
    form = $urandom_range(0, 9);
    if (form < 5) begin
      add_decimal_body();
      if (coin(30)) begin
        add_cp(CH_SLASH);
        if (coin(80)) add_decimal_body();
      end
      if (coin(30)) add_cp(coin(50) ? CH_LI : CH_UI);
    end else if (form < 7) begin
      if (coin(20)) begin
        add_cp(CP_INFINITY);
      end else begin
        word = coin(50) ? "infinity" : "nan";
        n = coin(60) ? word.len() : $urandom_range(1, word.len());
        for (int k = 0; k < n; k++) add_cp(coin(50) ? word[k] : word[k] - 32);
      end
      if (coin(30)) add_cp(coin(50) ? CH_LI : CH_UI);
    end else if (form < 9) begin
      if (coin(40)) begin
        add_cp(coin(50) ? $urandom_range('hBC, 'hBE) : $urandom_range('h2150, 'h215E));
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) add_cp(rand_super());
        if (coin(85)) add_cp(CP_FRACTION_SLASH);
        n = $urandom_range(0, 3);
        repeat (n) add_cp(CP_SUB_ZERO + $urandom_range(0, 9));
      end
      if (coin(30)) add_cp(coin(50) ? CH_LI : CH_UI);
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) add_cp(rand_char());
    end
    // Close with some other character or the end of text; otherwise the
    // next scan start cuts this one off.
    n = $urandom_range(0, 99);
    if (n < 70) add_cp(rand_char());
    else if (n < 85) add_char($urandom_range(0, 'h1FFFFF), 3'($urandom_range(0, 7)), 1'b1);
    if (coin(15)) begin
      add_char(rand_char(), 3'($urandom_range(0, 7)), coin(30));
      chars_queued--;
    end
  endtask

  task automatic wait_drained();
    while (pending_chars.size() != 0 || s_axis_tvalid || expected_tokens.size() != 0)
      @(posedge clk_i);
    // Characters that settle no token may still be inside the block.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_special_values(input logic value);
    logic [31:0] readback;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ALLOW_SPECIAL;
    pwdata  <= {31'b0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    readback = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== {31'b0, value}) begin
      $error("allow_special_values: expected %0d, got %0d", value, readback);
      fault_count++;
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed scans with the special values enabled from reset.
    open_pending = 1'b1;
    add_text("-1e+2/3i");
    open_pending = 1'b1;
    add_text("9/");
    add_char(0, 3'd0, 1'b1);
    open_pending = 1'b1;
    add_char(CP_INFINITY, 3'd3, 1'b0);
    open_pending = 1'b1;
    add_text("Inf?");
    open_pending = 1'b1;
    add_char('hBE, 3'd2, 1'b0);
    add_char(CH_UI, 3'd1, 1'b0);
    open_pending = 1'b1;
    add_char('hB2, 3'd2, 1'b0);
    add_char(CP_FRACTION_SLASH, 3'd3, 1'b0);
    add_char('h2083, 3'd3, 1'b0);
    add_char('h1FFFFF, 3'd7, 1'b1);
    // A new scan cuts in; its digit has zero width, so its result is an empty token.
    open_pending = 1'b1;
    add_text("5");
    open_pending = 1'b1;
    add_char(CH_0 + 7, 3'd0, 1'b0);
    add_char(0, 3'd0, 1'b1);
    open_pending = 1'b1;
    add_char(0, 3'd0, 1'b1);
    open_pending = 1'b1;
    add_char('h1FFFFF, 3'd7, 1'b0);
    add_text("x");
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      set_special_values(p[0]);
      chars_queued = 0;
      while (chars_queued < PHASE_CHARS) add_random_scan();
      wait_drained();
    end

    if (fault_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
